// File: sv/note_byte_tone_envelope_controller_core_defines.svh
// Assertion macros for the note byte tone envelope controller.
// Used by the top level; needs clk and rst_n in scope.
`ifndef NOTE_BYTE_TONE_ENVELOPE_CONTROLLER_CORE_DEFINES_SVH
`define NOTE_BYTE_TONE_ENVELOPE_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define NBTEC_ASSERT_NOW(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication
`define NBTEC_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: sv/nbtec_pkg.sv
// Shared types, constants and the tone table of the note byte tone envelope controller.
// No dependencies.
package nbtec_pkg;

    localparam int DUTY_BITS = 10;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

    localparam logic [7:0] ATTACK_PEAK  = 8'd220;
    localparam logic [7:0] ATTACK_STEP  = 8'd12;
    localparam logic [7:0] ATTACK_LAST  = 8'((220 / 12) * 12);
    localparam logic [7:0] DECAY_STEP   = 8'd6;
    localparam logic [7:0] RELEASE_STEP = 8'd8;
    localparam logic [3:0] NOTE_LAST    = 4'd11;
    localparam logic [3:0] NOTE_SILENCE = 4'd15;
    localparam logic [15:0] IDLE_MAX    = 16'hFFFF;

    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [7:0]  SUSTAIN_RESET = 8'd90;

    // configuration register indexes
    localparam logic [0:0] REG_SILENCE_TIMEOUT = 1'b0;
    localparam logic [0:0] REG_SUSTAIN_LEVEL   = 1'b1;

    // request types
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // command kinds
    localparam logic CMD_PLAY    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [11:0] TONE_TABLE [96] = '{
        12'd16, 12'd17, 12'd18, 12'd19, 12'd21, 12'd22,
        12'd23, 12'd24, 12'd26, 12'd28, 12'd29, 12'd31,
        12'd33, 12'd35, 12'd37, 12'd39, 12'd41, 12'd44,
        12'd46, 12'd49, 12'd52, 12'd55, 12'd58, 12'd62,
        12'd65, 12'd69, 12'd73, 12'd78, 12'd82, 12'd87,
        12'd92, 12'd98, 12'd104, 12'd110, 12'd117, 12'd123,
        12'd131, 12'd139, 12'd147, 12'd156, 12'd165, 12'd175,
        12'd185, 12'd196, 12'd208, 12'd220, 12'd233, 12'd247,
        12'd262, 12'd277, 12'd294, 12'd311, 12'd330, 12'd349,
        12'd370, 12'd392, 12'd415, 12'd440, 12'd466, 12'd494,
        12'd523, 12'd554, 12'd587, 12'd622, 12'd659, 12'd698,
        12'd740, 12'd784, 12'd831, 12'd880, 12'd932, 12'd988,
        12'd1047, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397,
        12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976,
        12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
        12'd2960, 12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951
    };

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [11:0]          tone_hz;
        logic [DUTY_BITS-1:0] duty;
        logic [1:0]           hold_ms;
        logic                 last;
        logic                 sound_on;
        logic [31:0]          byte_count;
        logic [31:0]          note_count;
        logic [31:0]          silence_count;
        logic [31:0]          invalid_count;
    } out_item_t;

    typedef struct packed {
        logic        kind;
        logic [11:0] tone;
        logic        is_byte;
        logic        is_silence;
        logic        is_invalid;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [DUTY_BITS-1:0] clamp_duty(input logic [7:0] d);
        logic [DUTY_BITS-1:0] r;
        if (32'(d) > 32'(DUTY_MAX))
            r = DUTY_MAX;
        else
            r = DUTY_BITS'(d);
        return r;
    endfunction

endpackage

// File: sv/nbtec_front.sv
// Front end: takes requests, keeps the idle timer, classifies bytes into commands and releases on silence timeout.
// Depends on nbtec_pkg.
module nbtec_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nbtec_pkg::in_item_t item,
    input  logic [15:0]         silence_timeout,
    input  nbtec_pkg::q_status_t q_status,
    output logic                full,
    output nbtec_pkg::cmd_push_t cmd_push
);
    import nbtec_pkg::*;

    logic [15:0] idle_reg, idle_next;
    logic        sounding_reg, sounding_next;   // sounding as it will be once queued work is done
    logic        accept;
    logic [2:0]  octave;
    logic [3:0]  note;
    logic [6:0]  tone_idx;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;
    assign octave = item.rx_byte[6:4];
    assign note   = item.rx_byte[3:0];
    assign tone_idx = 7'(octave) * 7'd12 + 7'(note);

    always_comb
    begin
        idle_next     = idle_reg;
        sounding_next = sounding_reg;
        cmd_push      = '0;
        cmd_push.cmd.kind = CMD_RELEASE;
        if (accept)
        begin
            if (item.req_type == REQ_TICK)
            begin
                if (idle_reg != IDLE_MAX)
                    idle_next = idle_reg + 16'd1;
                if (sounding_reg && (idle_next >= silence_timeout))
                begin
                    cmd_push.valid = 1'b1;
                    sounding_next  = 1'b0;
                end
            end
            else
            begin
                idle_next = '0;
                cmd_push.valid       = 1'b1;
                cmd_push.cmd.is_byte = 1'b1;
                if (note <= NOTE_LAST)
                begin
                    cmd_push.cmd.kind = CMD_PLAY;
                    cmd_push.cmd.tone = TONE_TABLE[tone_idx];
                    sounding_next     = 1'b1;
                end
                else
                begin
                    cmd_push.cmd.is_silence = (note == NOTE_SILENCE);
                    cmd_push.cmd.is_invalid = (note != NOTE_SILENCE);
                    sounding_next           = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg     <= '0;
            sounding_reg <= 1'b0;
        end
        else
        begin
            idle_reg     <= idle_next;
            sounding_reg <= sounding_next;
        end
    end

endmodule

// File: sv/nbtec_cmd_queue.sv
// Two-entry command queue between front end and envelope sequencer.
// Depends on nbtec_pkg.
module nbtec_cmd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nbtec_pkg::cmd_push_t cmd_push,
    input  logic                 cmd_pop,
    output nbtec_pkg::cmd_t      head,
    output nbtec_pkg::q_status_t q_status
);
    import nbtec_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.empty = (count_reg == 2'd0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = cmd_push.valid && !q_status.full;
    assign do_pop  = cmd_pop && !q_status.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= cmd_push.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/nbtec_back.sv
// Envelope sequencer: attack, decay, release ramps, one step per cycle while the
// single output register is free or popped. Holds the counters. Needs nbtec_pkg.
module nbtec_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nbtec_pkg::cmd_t      head,
    input  nbtec_pkg::q_status_t q_status,
    input  logic [7:0]           sustain_level,
    input  logic                 pop,
    output logic                 cmd_pop,
    output logic                 empty,
    output nbtec_pkg::out_item_t result
);
    import nbtec_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ATTACK   = 3'd1;
    localparam logic [2:0] ST_DECAY    = 3'd2;
    localparam logic [2:0] ST_PLAY_END = 3'd3;
    localparam logic [2:0] ST_RELEASE  = 3'd4;
    localparam logic [2:0] ST_REL_END  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  duty_reg, duty_next;
    logic [11:0] tone_reg, tone_next;
    logic        silence_reg, silence_next;
    logic        sounding_reg, sounding_next;
    logic [11:0] cur_tone_reg, cur_tone_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [31:0] notes_reg, notes_next;
    logic [31:0] silences_reg, silences_next;
    logic [31:0] invalids_reg, invalids_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;
    logic        emit_ok, emit;
    logic [11:0] step_tone;
    logic [7:0]  step_duty;
    logic [1:0]  step_hold;
    logic        step_last;

    assign emit_ok = !out_valid_reg || pop;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_comb
    begin
        state_next    = state_reg;
        duty_next     = duty_reg;
        tone_next     = tone_reg;
        silence_next  = silence_reg;
        sounding_next = sounding_reg;
        cur_tone_next = cur_tone_reg;
        bytes_next    = bytes_reg;
        notes_next    = notes_reg;
        silences_next = silences_reg;
        invalids_next = invalids_reg;
        cmd_pop       = 1'b0;
        emit          = 1'b0;
        step_tone     = tone_reg;
        step_duty     = duty_reg;
        step_hold     = 2'd2;
        step_last     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    cmd_pop = 1'b1;
                    if (head.is_byte)
                        bytes_next = bytes_reg + 32'd1;
                    if (head.kind == CMD_PLAY)
                    begin
                        tone_next  = head.tone;
                        duty_next  = '0;
                        state_next = ST_ATTACK;
                    end
                    else
                    begin
                        if (head.is_invalid)
                            invalids_next = invalids_reg + 32'd1;
                        tone_next    = cur_tone_reg;
                        duty_next    = sustain_level;
                        silence_next = head.is_silence;
                        state_next   = ST_RELEASE;
                    end
                end
            end
            ST_ATTACK:
            begin
                step_hold = 2'd1;
                if (emit_ok)
                begin
                    emit = 1'b1;
                    if (duty_reg == ATTACK_LAST)
                    begin
                        duty_next  = ATTACK_PEAK;
                        state_next = (sustain_level <= ATTACK_PEAK) ? ST_DECAY : ST_PLAY_END;
                    end
                    else
                        duty_next = duty_reg + ATTACK_STEP;
                end
            end
            ST_DECAY:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    // next step only if it stays at or above sustain
                    if (9'(duty_reg) >= 9'(sustain_level) + 9'(DECAY_STEP))
                        duty_next = duty_reg - DECAY_STEP;
                    else
                        state_next = ST_PLAY_END;
                end
            end
            ST_PLAY_END:
            begin
                step_duty = sustain_level;
                step_hold = 2'd0;
                step_last = 1'b1;
                if (emit_ok)
                begin
                    emit          = 1'b1;
                    sounding_next = 1'b1;
                    cur_tone_next = tone_reg;
                    notes_next    = notes_reg + 32'd1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RELEASE:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    if (duty_reg >= RELEASE_STEP)
                        duty_next = duty_reg - RELEASE_STEP;
                    else
                        state_next = ST_REL_END;
                end
            end
            ST_REL_END:
            begin
                step_tone = '0;
                step_duty = '0;
                step_hold = 2'd0;
                step_last = 1'b1;
                if (emit_ok)
                begin
                    emit          = 1'b1;
                    sounding_next = 1'b0;
                    cur_tone_next = '0;
                    if (silence_reg)
                        silences_next = silences_reg + 32'd1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next.tone_hz       = step_tone;
        out_next.duty          = clamp_duty(step_duty);
        out_next.hold_ms       = step_hold;
        out_next.last          = step_last;
        out_next.sound_on      = sounding_next;
        out_next.byte_count    = bytes_next;
        out_next.note_count    = notes_next;
        out_next.silence_count = silences_next;
        out_next.invalid_count = invalids_next;
        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= out_next;
        duty_reg    <= duty_next;
        tone_reg    <= tone_next;
        silence_reg <= silence_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sounding_reg  <= 1'b0;
            cur_tone_reg  <= '0;
            bytes_reg     <= '0;
            notes_reg     <= '0;
            silences_reg  <= '0;
            invalids_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sounding_reg  <= sounding_next;
            cur_tone_reg  <= cur_tone_next;
            bytes_reg     <= bytes_next;
            notes_reg     <= notes_next;
            silences_reg  <= silences_next;
            invalids_reg  <= invalids_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/note_byte_tone_envelope_controller_core.sv
// Top level of the note byte tone envelope controller: config registers,
// front end, command queue, envelope sequencer. Depends on nbtec_pkg and the defines header.
//
//   channel  | handshake       | payload
//   ---------+-----------------+---------------------------
//   request  | push / full     | item   (in_item_t)
//   result   | empty / pop     | result (out_item_t)
//   config   | cfg_we          | cfg_index, cfg_data
//
// A request is taken while full is low; up to two commands wait in the queue.
// When idle the sequencer pops a command, then gives a result per step: a
// note: attack, decay if sustain <= attack peak, final; release: release, final.
// A tick that releases nothing gives no result.
// pop low holds the output register and stalls the sequencer; full rises when
// the queue holds two commands. Reset clears all control state and counters.
`include "note_byte_tone_envelope_controller_core_defines.svh"

module note_byte_tone_envelope_controller_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  nbtec_pkg::in_item_t  item,
    output logic                 empty,
    input  logic                 pop,
    output nbtec_pkg::out_item_t result,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import nbtec_pkg::*;

    logic [15:0] timeout_reg, timeout_next;
    logic [7:0]  sustain_reg, sustain_next;
    cmd_push_t   cmd_push;
    cmd_t        head;
    q_status_t   q_status;
    logic        cmd_pop;

    always_comb
    begin
        timeout_next = timeout_reg;
        sustain_next = sustain_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SILENCE_TIMEOUT: timeout_next = cfg_data;
                REG_SUSTAIN_LEVEL:   sustain_next = cfg_data[7:0];
                default:             timeout_next = timeout_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            sustain_reg <= SUSTAIN_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
            sustain_reg <= sustain_next;
        end
    end

    nbtec_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .item            (item),
        .silence_timeout (timeout_reg),
        .q_status        (q_status),
        .full            (full),
        .cmd_push        (cmd_push)
    );

    nbtec_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_push (cmd_push),
        .cmd_pop  (cmd_pop),
        .head     (head),
        .q_status (q_status)
    );

    nbtec_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .sustain_level (sustain_reg),
        .pop           (pop),
        .cmd_pop       (cmd_pop),
        .empty         (empty),
        .result        (result)
    );

    `NBTEC_ASSERT_NOW(a_no_push_when_full, cmd_push.valid, !q_status.full, "command pushed into full queue")
    `NBTEC_ASSERT_NOW(a_no_pop_when_empty, cmd_pop, !q_status.empty, "command popped from empty queue")
    `NBTEC_ASSERT_NOW(a_last_no_hold, !empty && result.last, result.hold_ms == 2'd0, "final step with hold")
    `NBTEC_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result), "waiting result changed")

endmodule
